// ----- src/lvid_pkg.sv -----
// ----------------------------------------------------------------------------
// lvid_pkg
// Shared widths and channel types of the RE8 Voronoi index decoder.
// ----------------------------------------------------------------------------
package lvid_pkg;

   localparam int ORDER_W       = 4;
   localparam int IDX_W         = 8;
   localparam int CODE_W        = 12;
   localparam int LANES         = 8;
   localparam int LANE_IW       = 3;
   // y0 = k7 + 4*k0 + 2*(k1..k6) stays below 17 * 2^IDX_W
   localparam int Y_W           = IDX_W + 5;
   // signed coordinate width (y0 - 2 may go negative)
   localparam int U_W           = Y_W + 1;
   localparam int MAX_ORDER_DEF = 8;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [IDX_W-1:0]   idx_0;
      logic [IDX_W-1:0]   idx_1;
      logic [IDX_W-1:0]   idx_2;
      logic [IDX_W-1:0]   idx_3;
      logic [IDX_W-1:0]   idx_4;
      logic [IDX_W-1:0]   idx_5;
      logic [IDX_W-1:0]   idx_6;
      logic [IDX_W-1:0]   idx_7;
   } lvid_req_type;

   typedef struct packed {
      logic signed [CODE_W-1:0] code_0;
      logic signed [CODE_W-1:0] code_1;
      logic signed [CODE_W-1:0] code_2;
      logic signed [CODE_W-1:0] code_3;
      logic signed [CODE_W-1:0] code_4;
      logic signed [CODE_W-1:0] code_5;
      logic signed [CODE_W-1:0] code_6;
      logic signed [CODE_W-1:0] code_7;
   } lvid_rsp_type;

endpackage

// ----- src/lvid_lane.sv -----
// ----------------------------------------------------------------------------
// lvid_lane
// One coordinate: quotient and remainder by m, then rounding to the nearest
// even integer for the even coset and for the odd coset, with remainders.
// ----------------------------------------------------------------------------
module lvid_lane import lvid_pkg::*; #(
   parameter int SHIFT_W = 4,
   parameter int R_W     = 11
) (
   input  logic [SHIFT_W-1:0]  shift,
   input  logic signed [U_W-1:0] u,
   output logic signed [U_W-1:0] w_even,
   output logic signed [U_W-1:0] w_odd,
   output logic signed [R_W-1:0] rem_even,
   output logic signed [R_W-1:0] rem_odd,
   output logic [R_W-2:0]        mag_even,
   output logic [R_W-2:0]        mag_odd
);

   logic signed [R_W-1:0] m;
   logic [U_W-1:0]        u_abs;
   logic [U_W-1:0]        mask;
   logic [U_W-1:0]        ra_mag;
   logic signed [R_W-1:0] ra;
   logic signed [R_W-1:0] rb;
   logic signed [U_W-1:0] z;
   logic signed [U_W-1:0] x1;
   logic signed [U_W-1:0] x      [2];
   logic signed [U_W-1:0] w      [2];
   logic signed [R_W-1:0] r_pre  [2];
   logic signed [R_W-1:0] r_post [2];
   logic [R_W-2:0]        mag    [2];

   always_comb begin
      m      = R_W'(1) << shift;
      u_abs  = u[U_W-1] ? U_W'(-u) : U_W'(u);
      mask   = ~({U_W{1'b1}} << shift);
      ra_mag = u_abs & mask;
      // truncating remainder: takes the sign of the dividend
      ra     = u[U_W-1] ? -R_W'(ra_mag) : R_W'(ra_mag);
      // floor division
      z      = u >>> shift;

      if (z == '0) begin
         if (ra == '0) begin
            x1 = '1;
            rb = ra;
         end else begin
            x1 = '0;
            rb = ra - m;
         end
      end else begin
         x1 = z - U_W'(1);
         rb = ra;
      end

      x[0]     = z;
      x[1]     = x1;
      r_pre[0] = ra;
      r_pre[1] = rb;

      // odd values round away from zero to the next even value
      for (int c = 0; c < 2; c++) begin
         if (x[c][0]) begin
            if (x[c][U_W-1]) begin
               w[c]      = x[c] - U_W'(1);
               r_post[c] = m - r_pre[c];
            end else begin
               w[c]      = x[c] + U_W'(1);
               r_post[c] = r_pre[c] - m;
            end
         end else begin
            w[c]      = x[c];
            r_post[c] = r_pre[c];
         end
         mag[c] = r_post[c][R_W-1] ? (R_W-1)'(-r_post[c]) : (R_W-1)'(r_post[c]);
      end
   end

   assign w_even   = w[0];
   assign w_odd    = w[1];
   assign rem_even = r_post[0];
   assign rem_odd  = r_post[1];
   assign mag_even = mag[0];
   assign mag_odd  = mag[1];

endmodule

// ----- src/lvid_parity.sv -----
// ----------------------------------------------------------------------------
// lvid_parity
// Merge of the eight lanes for one coset: checks the sum modulo 4 and moves
// the first entry with the largest remainder magnitude by two.
// ----------------------------------------------------------------------------
module lvid_parity import lvid_pkg::*; #(
   parameter int SHIFT_W = 4,
   parameter int R_W     = 11
) (
   input  logic [SHIFT_W-1:0]    shift,
   input  logic signed [U_W-1:0] w       [LANES],
   input  logic signed [R_W-1:0] rem     [LANES],
   input  logic [R_W-2:0]        mag     [LANES],
   output logic signed [U_W-1:0] w_fix   [LANES],
   output logic signed [R_W-1:0] rem_fix [LANES]
);

   logic signed [R_W-1:0] m2;
   logic                  odd_sum;
   logic [R_W-2:0]        l1_mag [4];
   logic [LANE_IW-1:0]    l1_idx [4];
   logic [R_W-2:0]        l2_mag [2];
   logic [LANE_IW-1:0]    l2_idx [2];
   logic [LANE_IW-1:0]    sel;

   always_comb begin
      m2      = R_W'(2) << shift;
      odd_sum = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         odd_sum = odd_sum ^ w[i][1];
      end

      // the right side wins only when strictly larger: keeps the first maximum
      for (int i = 0; i < 4; i++) begin
         if (mag[2*i+1] > mag[2*i]) begin
            l1_mag[i] = mag[2*i+1];
            l1_idx[i] = LANE_IW'(2*i+1);
         end else begin
            l1_mag[i] = mag[2*i];
            l1_idx[i] = LANE_IW'(2*i);
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (l1_mag[2*i+1] > l1_mag[2*i]) begin
            l2_mag[i] = l1_mag[2*i+1];
            l2_idx[i] = l1_idx[2*i+1];
         end else begin
            l2_mag[i] = l1_mag[2*i];
            l2_idx[i] = l1_idx[2*i];
         end
      end
      sel = (l2_mag[1] > l2_mag[0]) ? l2_idx[1] : l2_idx[0];

      for (int i = 0; i < LANES; i++) begin
         w_fix[i]   = w[i];
         rem_fix[i] = rem[i];
         if (odd_sum && (LANE_IW'(i) == sel)) begin
            if (rem[i][R_W-1]) begin
               w_fix[i]   = w[i] - U_W'(2);
               rem_fix[i] = rem[i] + m2;
            end else begin
               w_fix[i]   = w[i] + U_W'(2);
               rem_fix[i] = rem[i] - m2;
            end
         end
      end
   end

endmodule

// ----- src/lattice_voronoi_index_decode_unit.sv -----
// ----------------------------------------------------------------------------
// lattice_voronoi_index_decode_unit
// RE8 Voronoi extension index decode: builds y from the index vector, finds
// the nearest RE8 point v to y/m over two 2D8 cosets and returns c = y - m*v.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | lvid_req_type (order, idx_0..7)
//   rsp     | out | rsp_valid/rsp_stall  | lvid_rsp_type (code_0..7)
//
// One vector per cycle while rsp_stall is low; six register stages (input
// register, index sums, eight lanes, coset merge, squares, error compare with
// output register), and rsp_valid is the valid of the output register.
// Each stage has its own valid; a stage takes new data when it is empty or
// its successor takes its content, so bubbles close up under rsp_stall.
// Reset clears all stage valids; payload registers are not reset.
// ----------------------------------------------------------------------------
module lattice_voronoi_index_decode_unit import lvid_pkg::*; #(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lvid_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lvid_rsp_type rsp_data
);

   localparam int SHIFT_W = $clog2(MAX_ORDER + 1);
   localparam int R_W     = MAX_ORDER + 3;
   localparam int MAG_W   = R_W - 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int E_W     = SQ_W + 3;
   localparam int NSTG    = 6;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] rdy;

   // stage 1: index entries and clamped order
   logic [IDX_W-1:0]   p1_k_in [LANES];
   logic [IDX_W-1:0]   p1_k_ff [LANES];
   logic [SHIFT_W-1:0] p1_shift_in;
   logic [SHIFT_W-1:0] p1_shift_ff;

   // stage 2: lattice point y
   logic [Y_W-1:0]     acc;
   logic [Y_W-1:0]     p2_y_in [LANES];
   logic [Y_W-1:0]     p2_y_ff [LANES];
   logic [SHIFT_W-1:0] p2_shift_ff;

   // stage 3: lane results for both cosets
   logic signed [U_W-1:0] lane_u  [LANES];
   logic signed [U_W-1:0] p3_w0_in [LANES];
   logic signed [U_W-1:0] p3_w1_in [LANES];
   logic signed [R_W-1:0] p3_r0_in [LANES];
   logic signed [R_W-1:0] p3_r1_in [LANES];
   logic [MAG_W-1:0]      p3_m0_in [LANES];
   logic [MAG_W-1:0]      p3_m1_in [LANES];
   logic signed [U_W-1:0] p3_w0_ff [LANES];
   logic signed [U_W-1:0] p3_w1_ff [LANES];
   logic signed [R_W-1:0] p3_r0_ff [LANES];
   logic signed [R_W-1:0] p3_r1_ff [LANES];
   logic [MAG_W-1:0]      p3_m0_ff [LANES];
   logic [MAG_W-1:0]      p3_m1_ff [LANES];
   logic [CODE_W-1:0]     p3_y_ff  [LANES];
   logic [SHIFT_W-1:0]    p3_shift_ff;

   // stage 4: parity-fixed candidates
   logic signed [U_W-1:0] p4_v0_in [LANES];
   logic signed [U_W-1:0] p4_v1_in [LANES];
   logic signed [R_W-1:0] p4_r0_in [LANES];
   logic signed [R_W-1:0] p4_r1_in [LANES];
   logic signed [U_W-1:0] p4_v0_ff [LANES];
   logic signed [U_W-1:0] p4_v1_ff [LANES];
   logic signed [R_W-1:0] p4_r0_ff [LANES];
   logic signed [R_W-1:0] p4_r1_ff [LANES];
   logic [CODE_W-1:0]     p4_y_ff  [LANES];
   logic [SHIFT_W-1:0]    p4_shift_ff;
   logic                  p4_par0;
   logic                  p4_par1;

   // stage 5: squared remainders
   logic [MAG_W-1:0]   mag0 [LANES];
   logic [MAG_W-1:0]   mag1 [LANES];
   logic [SQ_W-1:0]    p5_sq0_in [LANES];
   logic [SQ_W-1:0]    p5_sq1_in [LANES];
   logic [SQ_W-1:0]    p5_sq0_ff [LANES];
   logic [SQ_W-1:0]    p5_sq1_ff [LANES];
   logic [CODE_W-1:0]  p5_v0_ff  [LANES];
   logic [CODE_W-1:0]  p5_v1_ff  [LANES];
   logic [CODE_W-1:0]  p5_y_ff   [LANES];
   logic [SHIFT_W-1:0] p5_shift_ff;

   // stage 6: output register
   logic [E_W-1:0]    e0;
   logic [E_W-1:0]    e1;
   logic              take_even;
   logic [CODE_W-1:0] vsel [LANES];
   logic [CODE_W-1:0] code [LANES];
   lvid_rsp_type      rsp_data_in;
   lvid_rsp_type      rsp_data_ff;

   // ------------------------------------------------------------------------
   // flow control
   // ------------------------------------------------------------------------
   always_comb begin
      rdy[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int s = NSTG - 2; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int s = 1; s < NSTG; s++) begin
         vld_in[s] = rdy[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------------
   always_comb begin
      p1_k_in[0] = req_data.idx_0;
      p1_k_in[1] = req_data.idx_1;
      p1_k_in[2] = req_data.idx_2;
      p1_k_in[3] = req_data.idx_3;
      p1_k_in[4] = req_data.idx_4;
      p1_k_in[5] = req_data.idx_5;
      p1_k_in[6] = req_data.idx_6;
      p1_k_in[7] = req_data.idx_7;
      // saturate the order
      p1_shift_in = (req_data.order > ORDER_W'(MAX_ORDER)) ? SHIFT_W'(MAX_ORDER)
                                                           : SHIFT_W'(req_data.order);
   end

   // generator-matrix sums
   always_comb begin
      acc = '0;
      for (int i = 1; i < LANES - 1; i++) begin
         acc = acc + Y_W'({p1_k_ff[i], 1'b0});
         p2_y_in[i] = Y_W'(p1_k_ff[LANES-1]) + Y_W'({p1_k_ff[i], 1'b0});
      end
      p2_y_in[LANES-1] = Y_W'(p1_k_ff[LANES-1]);
      p2_y_in[0] = Y_W'(p1_k_ff[LANES-1]) + Y_W'({p1_k_ff[0], 2'b00}) + acc;
   end

   always_comb begin
      // entry 0 is searched around y0 - 2
      lane_u[0] = U_W'(p2_y_ff[0]) - U_W'(2);
      for (int i = 1; i < LANES; i++) begin
         lane_u[i] = U_W'(p2_y_ff[i]);
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      lvid_lane #(
         .SHIFT_W (SHIFT_W),
         .R_W     (R_W)
      ) u_lane (
         .shift    (p2_shift_ff),
         .u        (lane_u[g]),
         .w_even   (p3_w0_in[g]),
         .w_odd    (p3_w1_in[g]),
         .rem_even (p3_r0_in[g]),
         .rem_odd  (p3_r1_in[g]),
         .mag_even (p3_m0_in[g]),
         .mag_odd  (p3_m1_in[g])
      );
   end

   lvid_parity #(
      .SHIFT_W (SHIFT_W),
      .R_W     (R_W)
   ) u_parity_even (
      .shift   (p3_shift_ff),
      .w       (p3_w0_ff),
      .rem     (p3_r0_ff),
      .mag     (p3_m0_ff),
      .w_fix   (p4_v0_in),
      .rem_fix (p4_r0_in)
   );

   lvid_parity #(
      .SHIFT_W (SHIFT_W),
      .R_W     (R_W)
   ) u_parity_odd (
      .shift   (p3_shift_ff),
      .w       (p3_w1_ff),
      .rem     (p3_r1_ff),
      .mag     (p3_m1_ff),
      .w_fix   (p4_v1_in),
      .rem_fix (p4_r1_in)
   );

   always_comb begin
      p4_par0 = 1'b0;
      p4_par1 = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         p4_par0 = p4_par0 ^ p4_v0_ff[i][1];
         p4_par1 = p4_par1 ^ p4_v1_ff[i][1];
         mag0[i] = p4_r0_ff[i][R_W-1] ? MAG_W'(-p4_r0_ff[i]) : MAG_W'(p4_r0_ff[i]);
         mag1[i] = p4_r1_ff[i][R_W-1] ? MAG_W'(-p4_r1_ff[i]) : MAG_W'(p4_r1_ff[i]);
         p5_sq0_in[i] = SQ_W'(mag0[i]) * SQ_W'(mag0[i]);
         p5_sq1_in[i] = SQ_W'(mag1[i]) * SQ_W'(mag1[i]);
      end
   end

   // pick the coset with the smaller error, odd coset on a tie
   always_comb begin
      e0 = '0;
      e1 = '0;
      for (int i = 0; i < LANES; i++) begin
         e0 = e0 + E_W'(p5_sq0_ff[i]);
         e1 = e1 + E_W'(p5_sq1_ff[i]);
      end
      take_even = e0 < e1;
      for (int i = 0; i < LANES; i++) begin
         vsel[i] = take_even ? p5_v0_ff[i] : p5_v1_ff[i] + CODE_W'(1);
         code[i] = p5_y_ff[i] - CODE_W'(vsel[i] << p5_shift_ff);
      end
      rsp_data_in.code_0 = code[0];
      rsp_data_in.code_1 = code[1];
      rsp_data_in.code_2 = code[2];
      rsp_data_in.code_3 = code[3];
      rsp_data_in.code_4 = code[4];
      rsp_data_in.code_5 = code[5];
      rsp_data_in.code_6 = code[6];
      rsp_data_in.code_7 = code[7];
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         p1_k_ff     <= p1_k_in;
         p1_shift_ff <= p1_shift_in;
      end
      if (rdy[1]) begin
         p2_y_ff     <= p2_y_in;
         p2_shift_ff <= p1_shift_ff;
      end
      if (rdy[2]) begin
         p3_w0_ff    <= p3_w0_in;
         p3_w1_ff    <= p3_w1_in;
         p3_r0_ff    <= p3_r0_in;
         p3_r1_ff    <= p3_r1_in;
         p3_m0_ff    <= p3_m0_in;
         p3_m1_ff    <= p3_m1_in;
         p3_shift_ff <= p2_shift_ff;
         for (int i = 0; i < LANES; i++) begin
            p3_y_ff[i] <= p2_y_ff[i][CODE_W-1:0];
         end
      end
      if (rdy[3]) begin
         p4_v0_ff    <= p4_v0_in;
         p4_v1_ff    <= p4_v1_in;
         p4_r0_ff    <= p4_r0_in;
         p4_r1_ff    <= p4_r1_in;
         p4_y_ff     <= p3_y_ff;
         p4_shift_ff <= p3_shift_ff;
      end
      if (rdy[4]) begin
         p5_sq0_ff   <= p5_sq0_in;
         p5_sq1_ff   <= p5_sq1_in;
         p5_y_ff     <= p4_y_ff;
         p5_shift_ff <= p4_shift_ff;
         for (int i = 0; i < LANES; i++) begin
            p5_v0_ff[i] <= p4_v0_ff[i][CODE_W-1:0];
            p5_v1_ff[i] <= p4_v1_ff[i][CODE_W-1:0];
         end
      end
      if (rdy[5]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && !rdy[3] |=> vld_ff[3])
      else $error("merge stage lost its content while blocked");

   a_even_par: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> !p4_par0)
      else $error("even coset candidate not in 2D8");

   a_odd_par: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> !p4_par1)
      else $error("odd coset candidate not in 2D8");

   a_empty_out: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output register");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RE8 Voronoi index decoder. Index vectors go in
// through the req channel with random gaps; every transfer is decoded by a
// behavioral copy of the lattice search and the code vectors coming out of
// rsp are compared lane by lane, in order, against those predictions.
// ----------------------------------------------------------------------------
module tb;
   import lvid_pkg::*;

   localparam int N_RANDOM   = 1700;
   localparam int QUIET_LO   = 400;
   localparam int QUIET_HI   = 700;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 80;
   localparam int DRAIN_AT   = 1000;
   localparam int TAIL_WAIT  = 20;
   localparam int IDLE_PCT   = 18;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lvid_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lvid_rsp_type rsp_data;

   lvid_req_type index_vec_q[$];
   lvid_rsp_type codes_due_q[$];

   int sent_count     = 0;
   int got_count      = 0;
   int mismatch_count = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   bit drain_done     = 1'b0;

   lattice_voronoi_index_decode_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Decode one index vector: nearest RE8 point to y/m over the even and the
   // odd 2D8 coset, then c = y - m*v truncated to the code width.
   function automatic lvid_rsp_type decode_codes(lvid_req_type vec);
      int shift, m, acc, t, sum, best, j, a, cs, i, c;
      int k[8], y[8], z[8];
      int xs[2][8], rm[2][8], pt[2][8];
      longint err[2];
      logic [8*CODE_W-1:0] flat;
      shift = int'(vec.order);
      if (shift > MAX_ORDER_DEF) shift = MAX_ORDER_DEF;
      m = 1 << shift;
      k[0] = int'(vec.idx_0); k[1] = int'(vec.idx_1);
      k[2] = int'(vec.idx_2); k[3] = int'(vec.idx_3);
      k[4] = int'(vec.idx_4); k[5] = int'(vec.idx_5);
      k[6] = int'(vec.idx_6); k[7] = int'(vec.idx_7);
      acc = 0;
      for (i = 0; i < 8; i++) y[i] = k[7];
      z[7] = y[7] >>> shift;
      rm[0][7] = y[7] & (m - 1);
      for (i = 6; i >= 1; i--) begin
         acc += 2 * k[i];
         y[i] += 2 * k[i];
         z[i] = y[i] >>> shift;
         rm[0][i] = y[i] & (m - 1);
      end
      y[0] += 4 * k[0] + acc;
      t = y[0] - 2;
      // floor quotient, but truncating remainder for entry 0
      if (t < 0) z[0] = -((-t + m - 1) >>> shift);
      else z[0] = t >>> shift;
      rm[0][0] = t % m;
      for (i = 0; i < 8; i++) begin
         xs[0][i] = z[i];
         rm[1][i] = rm[0][i];
         if (z[i] == 0) begin
            if (rm[1][i] == 0) begin
               xs[1][i] = -1;
            end else begin
               xs[1][i] = 0;
               rm[1][i] -= m;
            end
         end else begin
            xs[1][i] = z[i] - 1;
         end
      end
      for (cs = 0; cs < 2; cs++) begin
         sum = 0;
         for (i = 0; i < 8; i++) begin
            if (xs[cs][i] < 0) pt[cs][i] = -2 * ((1 - xs[cs][i]) >>> 1);
            else pt[cs][i] = 2 * ((1 + xs[cs][i]) >>> 1);
            sum += pt[cs][i];
            if (xs[cs][i] % 2 != 0) begin
               if (xs[cs][i] < 0) rm[cs][i] = m - rm[cs][i];
               else rm[cs][i] = rm[cs][i] - m;
            end
         end
         // parity repair: move the first entry with the largest remainder
         if (sum % 4 != 0) begin
            best = 0;
            j = 0;
            for (i = 0; i < 8; i++) begin
               a = (rm[cs][i] < 0) ? -rm[cs][i] : rm[cs][i];
               if (best < a) begin
                  best = a;
                  j = i;
               end
            end
            if (rm[cs][j] < 0) begin
               pt[cs][j] -= 2;
               rm[cs][j] += 2 * m;
            end else begin
               pt[cs][j] += 2;
               rm[cs][j] -= 2 * m;
            end
         end
         err[cs] = 0;
         for (i = 0; i < 8; i++) err[cs] += longint'(rm[cs][i]) * rm[cs][i];
      end
      for (i = 0; i < 8; i++) begin
         c = (err[0] < err[1]) ? y[i] - m * pt[0][i] : y[i] - m * (pt[1][i] + 1);
         flat[(7-i)*CODE_W +: CODE_W] = c[CODE_W-1:0];
      end
      return lvid_rsp_type'(flat);
   endfunction

   task automatic add_vec(input logic [ORDER_W-1:0] ord, input logic [8*IDX_W-1:0] idx);
      index_vec_q.push_back(lvid_req_type'({ord, idx}));
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver hold-off: one long stall so the pipeline fills and backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : drive
      int sent_now;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sent_now = sent_count;
         if (req_valid && !req_stall) begin
            codes_due_q.push_back(decode_codes(req_data));
            sent_now++;
            sent_count <= sent_now;
         end
         // a stalled transfer holds valid and payload
         if (!(req_valid && req_stall)) begin
            if (!drain_done && sent_now >= DRAIN_AT && codes_due_q.size() != 0) begin
               req_valid <= 1'b0;
            end else if ((sent_now < QUIET_LO || sent_now >= QUIET_HI) &&
                         $urandom_range(99) < IDLE_PCT) begin
               req_valid <= 1'b0;
            end else if (index_vec_q.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= index_vec_q.pop_front();
               if (sent_now >= DRAIN_AT) drain_done <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      lvid_rsp_type want;
      int lane;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (codes_due_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("tb: unexpected result %0d, nothing pending", got_count);
            end else begin
               want = codes_due_q.pop_front();
               for (lane = 0; lane < 8; lane++) begin
                  if (rsp_data[(7-lane)*CODE_W +: CODE_W] !==
                      want[(7-lane)*CODE_W +: CODE_W]) begin
                     mismatch_count++;
                     if (mismatch_count <= 10)
                        $display("tb: result %0d code_%0d expected %0d, got %0d",
                                 got_count, lane,
                                 $signed(want[(7-lane)*CODE_W +: CODE_W]),
                                 $signed(rsp_data[(7-lane)*CODE_W +: CODE_W]));
                  end
               end
            end
            got_count <= got_count + 1;
         end
         rsp_stall <= (hold_left > 1) ||
                      ((got_count < QUIET_LO || got_count >= QUIET_HI) &&
                       $urandom_range(99) < IDLE_PCT);
      end
   end

   initial begin
      int n, i, ord;
      logic [8*IDX_W-1:0] idx;
      // extremes of order and index, including saturation and unmasked entries
      add_vec(4'd1, {8{8'h00}});
      add_vec(4'd1, {56'h0, 8'h01});
      add_vec(4'd1, {8'h01, 56'h0});
      add_vec(4'd1, {8{8'h01}});
      add_vec(4'd1, {8'h00, 8'h01, 48'h0});
      add_vec(4'd8, {8{8'h00}});
      add_vec(4'd8, {8{8'hFF}});
      add_vec(4'd8, {8'hFF, 56'h0});
      add_vec(4'd8, {56'h0, 8'hFF});
      add_vec(4'd8, {4{8'h55, 8'hAA}});
      add_vec(4'd8, {8{8'h80}});
      add_vec(4'd0, {8{8'h00}});
      add_vec(4'd0, {56'h0, 8'h01});
      add_vec(4'd0, {8{8'hFF}});
      add_vec(4'd9, {4{8'hAA, 8'h55}});
      add_vec(4'd15, {8{8'hFF}});
      add_vec(4'd15, {8{8'h00}});
      add_vec(4'd3, {8{8'hFF}});
      add_vec(4'd2, {8{8'h03}});
      add_vec(4'd4, {4{8'h0F, 8'h00}});
      add_vec(4'd5, 64'h01_02_03_04_05_06_07_08);
      add_vec(4'd7, {8{8'h7F}});
      for (n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(99) < 75) begin
            ord = $urandom_range(1, MAX_ORDER_DEF);
            for (i = 0; i < 8; i++)
               idx[i*IDX_W +: IDX_W] = IDX_W'($urandom_range(0, (1 << ord) - 1));
         end else begin
            ord = $urandom_range(0, 15);
            for (i = 0; i < 8; i++) idx[i*IDX_W +: IDX_W] = IDX_W'($urandom_range(0, 255));
         end
         add_vec(ord[ORDER_W-1:0], idx);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (index_vec_q.size() != 0 || req_valid) @(posedge clock);
      while (codes_due_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
